@@ rtl/eos_pkg.sv @@
// ----------------------------------------------------------------------------
// eos_pkg
// Shared types and constants for the extent overlay splitter.
// ----------------------------------------------------------------------------
package eos_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int OFF_W  = 48;
	localparam int LEN_W  = 32;
	localparam int ADDR_W = 64;
	localparam int END_W  = OFF_W + 1;

	localparam logic [END_W-1:0] SPACE_END = {1'b1, {OFF_W{1'b0}}};

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACK,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_EMIT,
		ST_PUSH_L,
		ST_PUSH_R,
		ST_POP_RD,
		ST_POP_DAT
	} state_t;

endpackage

@@ rtl/eos_ram.sv @@
// ----------------------------------------------------------------------------
// eos_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module eos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/extent_overlay_splitter_core.sv @@
// ----------------------------------------------------------------------------
// extent_overlay_splitter_core
// Extent table with insert, clear and overlap-splitting query requests.
// ----------------------------------------------------------------------------
// One request at a time. Insert and clear pass through the ST_ACK state and
// return one acknowledge. A query returns one segment per piece; each piece
// costs a stack pop (ST_POP_RD, ST_POP_DAT), a table scan of a read and a
// compare state per entry checked by the single overlap compare unit, an emit
// state that waits while the output is stalled and two push states, with at
// most 2*TABLE_DEPTH+1 segments. The table and the piece stack sit in RAMs.
module extent_overlay_splitter_core #(
	parameter int TABLE_DEPTH = eos_pkg::DEF_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [eos_pkg::OFF_W-1:0]   offset,
	input  logic [eos_pkg::LEN_W-1:0]   length,
	input  logic [eos_pkg::ADDR_W-1:0]  address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [eos_pkg::OFF_W-1:0]   seg_offset,
	output logic [eos_pkg::LEN_W-1:0]   seg_length,
	output logic                        from_table,
	output logic [eos_pkg::ADDR_W-1:0]  seg_address,
	output logic                        accepted,
	output logic                        last
);

	localparam int OW  = eos_pkg::OFF_W;
	localparam int LW  = eos_pkg::LEN_W;
	localparam int AW  = eos_pkg::ADDR_W;
	localparam int EW  = eos_pkg::END_W;
	localparam int SD  = 2 * TABLE_DEPTH + 1;
	localparam int TAW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int SAW = $clog2(SD);
	localparam int SPW = $clog2(SD + 1);
	localparam int TWW = OW + LW + AW;
	localparam int SWW = OW + LW;

	eos_pkg::state_t state_q, state_nx;

	logic [CW-1:0]  count_q;
	logic [TAW-1:0] idx_q;
	logic [SPW-1:0] sp_q;
	logic [SPW-1:0] nseg_q;
	logic [1:0]     kind_q;
	logic           ack_ok_q;
	logic [AW-1:0]  qaddr_q;

	logic [OW-1:0] ps_q;
	logic [LW-1:0] pl_q;
	logic [EW-1:0] pe_q;

	logic [OW-1:0] sg_off_q;
	logic [LW-1:0] sg_len_q;
	logic          sg_tab_q;
	logic [AW-1:0] sg_addr_q;

	logic [OW-1:0] rs_q;
	logic [LW-1:0] rl_q;
	logic [LW-1:0] ll_q;
	logic          l_ok_q, r_ok_q, last_q;

	logic           tbl_we;
	logic [TWW-1:0] tbl_rdata;
	logic           stk_we;
	logic [SAW-1:0] stk_waddr, stk_raddr;
	logic [SWW-1:0] stk_wdata, stk_rdata;

	logic in_acc, out_free;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = state_q != eos_pkg::ST_IDLE;

	// query saturation
	logic [EW-1:0] q_end;
	logic [LW-1:0] q_len;
	assign q_end = EW'(offset) + EW'(length);
	assign q_len = (q_end > eos_pkg::SPACE_END) ? LW'(eos_pkg::SPACE_END - EW'(offset)) : length;

	// overlap compare unit
	logic [OW-1:0] e_s;
	logic [LW-1:0] e_l;
	logic [AW-1:0] e_a;
	logic [EW-1:0] e_end, lo, hi, span;
	logic [LW:0]   lsum;
	logic          hit, s1_gt;
	assign {e_s, e_l, e_a} = tbl_rdata;
	assign e_end = EW'(e_s) + EW'(e_l);
	assign s1_gt = e_s > ps_q;
	assign lo    = s1_gt ? EW'(ps_q) : EW'(e_s);
	assign hi    = (e_end > pe_q) ? e_end : pe_q;
	assign span  = hi - lo;
	assign lsum  = (LW + 1)'(e_l) + (LW + 1)'(pl_q);
	assign hit   = span < EW'(lsum);

	logic scan_end;
	assign scan_end = (CW'(idx_q) + CW'(1)) == count_q;

	// split bookkeeping
	logic [EW-1:0]  r_start;
	logic [LW-1:0]  l_len, r_len;
	logic           l_ok, r_ok;
	logic [SPW-1:0] sp1, sp2;
	assign r_start = EW'(sg_off_q) + EW'(sg_len_q);
	assign l_len   = LW'(sg_off_q - ps_q);
	assign r_len   = LW'(pe_q - r_start);
	assign l_ok    = (l_len != '0) && (sp_q < SPW'(SD));
	assign sp1     = sp_q + SPW'(l_ok);
	assign r_ok    = (r_len != '0) && (sp1 < SPW'(SD));
	assign sp2     = sp1 + SPW'(r_ok);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			eos_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (kind)
						eos_pkg::KIND_INSERT, eos_pkg::KIND_CLEAR: state_nx = eos_pkg::ST_ACK;
						eos_pkg::KIND_QUERY: begin
							if (q_len == '0) state_nx = eos_pkg::ST_IDLE;
							else if (count_q == '0) state_nx = eos_pkg::ST_EMIT;
							else state_nx = eos_pkg::ST_SCAN_RD;
						end
						default: state_nx = eos_pkg::ST_IDLE;
					endcase
				end
			end
			eos_pkg::ST_ACK: if (out_free) state_nx = eos_pkg::ST_IDLE;
			eos_pkg::ST_SCAN_RD: state_nx = eos_pkg::ST_SCAN_CMP;
			eos_pkg::ST_SCAN_CMP: begin
				if (hit || scan_end) state_nx = eos_pkg::ST_EMIT;
				else state_nx = eos_pkg::ST_SCAN_RD;
			end
			eos_pkg::ST_EMIT: if (out_free) state_nx = eos_pkg::ST_PUSH_L;
			eos_pkg::ST_PUSH_L: state_nx = eos_pkg::ST_PUSH_R;
			eos_pkg::ST_PUSH_R: state_nx = last_q ? eos_pkg::ST_IDLE : eos_pkg::ST_POP_RD;
			eos_pkg::ST_POP_RD: state_nx = eos_pkg::ST_POP_DAT;
			eos_pkg::ST_POP_DAT: begin
				if (count_q == '0) state_nx = eos_pkg::ST_EMIT;
				else state_nx = eos_pkg::ST_SCAN_RD;
			end
			default: state_nx = eos_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		tbl_we    = 1'b0;
		stk_we    = 1'b0;
		stk_waddr = sp_q[SAW-1:0];
		stk_wdata = {ps_q, ll_q};
		stk_raddr = SAW'(sp_q - SPW'(1));
		case (state_q)
			eos_pkg::ST_IDLE:
				tbl_we = in_acc && (kind == eos_pkg::KIND_INSERT) && (count_q < CW'(TABLE_DEPTH));
			eos_pkg::ST_PUSH_L: stk_we = l_ok_q;
			eos_pkg::ST_PUSH_R: begin
				stk_we    = r_ok_q;
				stk_wdata = {rs_q, rl_q};
			end
			default: ;
		endcase
	end

	eos_ram #(.WIDTH(TWW), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (count_q[TAW-1:0]),
		.wdata ({offset, length, address}),
		.raddr (idx_q),
		.rdata (tbl_rdata)
	);

	eos_ram #(.WIDTH(SWW), .DEPTH(SD)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eos_pkg::ST_IDLE;
			count_q <= '0;
			sp_q    <= '0;
			nseg_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				eos_pkg::ST_IDLE: begin
					idx_q  <= '0;
					sp_q   <= '0;
					nseg_q <= '0;
					if (in_acc && kind == eos_pkg::KIND_CLEAR) count_q <= '0;
					else if (tbl_we) count_q <= count_q + CW'(1);
				end
				eos_pkg::ST_SCAN_CMP: if (!hit && !scan_end) idx_q <= idx_q + TAW'(1);
				eos_pkg::ST_EMIT: if (out_free) nseg_q <= nseg_q + SPW'(1);
				eos_pkg::ST_PUSH_L: sp_q <= sp_q + SPW'(l_ok_q);
				eos_pkg::ST_PUSH_R: sp_q <= sp_q + SPW'(r_ok_q);
				eos_pkg::ST_POP_RD: sp_q <= sp_q - SPW'(1);
				eos_pkg::ST_POP_DAT: idx_q <= '0;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			eos_pkg::ST_IDLE: begin
				if (in_acc) begin
					kind_q   <= kind;
					ack_ok_q <= (kind == eos_pkg::KIND_CLEAR) || (count_q < CW'(TABLE_DEPTH));
					qaddr_q  <= address;
					ps_q     <= offset;
					pl_q     <= q_len;
					pe_q     <= EW'(offset) + EW'(q_len);
					sg_off_q  <= offset;
					sg_len_q  <= q_len;
					sg_tab_q  <= 1'b0;
					sg_addr_q <= address;
				end
			end
			eos_pkg::ST_SCAN_CMP: begin
				if (hit) begin
					sg_off_q  <= s1_gt ? e_s : ps_q;
					sg_len_q  <= LW'(EW'(lsum) - span);
					sg_tab_q  <= 1'b1;
					sg_addr_q <= s1_gt ? e_a : e_a + AW'(ps_q - e_s);
				end else if (scan_end) begin
					sg_off_q  <= ps_q;
					sg_len_q  <= pl_q;
					sg_tab_q  <= 1'b0;
					sg_addr_q <= qaddr_q;
				end
			end
			eos_pkg::ST_EMIT: begin
				rs_q   <= OW'(r_start);
				rl_q   <= r_len;
				ll_q   <= l_len;
				l_ok_q <= l_ok;
				r_ok_q <= r_ok;
				last_q <= (sp2 == '0) || ((nseg_q + SPW'(1)) == SPW'(SD));
			end
			eos_pkg::ST_POP_DAT: begin
				ps_q      <= stk_rdata[SWW-1:LW];
				pl_q      <= stk_rdata[LW-1:0];
				pe_q      <= EW'(stk_rdata[SWW-1:LW]) + EW'(stk_rdata[LW-1:0]);
				sg_off_q  <= stk_rdata[SWW-1:LW];
				sg_len_q  <= stk_rdata[LW-1:0];
				sg_tab_q  <= 1'b0;
				sg_addr_q <= qaddr_q;
			end
			default: ;
		endcase
	end

	// output register
	logic load_ack, load_seg;
	assign load_ack = (state_q == eos_pkg::ST_ACK) && out_free;
	assign load_seg = (state_q == eos_pkg::ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_ack || load_seg) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ack) begin
			seg_offset  <= '0;
			seg_length  <= '0;
			from_table  <= 1'b0;
			seg_address <= '0;
			accepted    <= ack_ok_q || (kind_q == eos_pkg::KIND_CLEAR);
			last        <= 1'b1;
		end else if (load_seg) begin
			seg_offset  <= sg_off_q;
			seg_length  <= sg_len_q;
			from_table  <= sg_tab_q;
			seg_address <= sg_addr_q;
			accepted    <= 1'b0;
			last        <= (sp2 == '0) || ((nseg_q + SPW'(1)) == SPW'(SD));
		end
	end

endmodule
